>>> design/spr_pkg.sv
// Shared types and constants for the sum-preserving pair resampler.
`timescale 1ns / 1ps

package spr_pkg;

  localparam int VALUE_W     = 11;
  localparam int NEW_VALUE_W = 12;
  localparam int RANDOM_W    = 32;
  localparam int CFG_DATA_W  = 11;
  localparam int CNT_W       = $clog2(RANDOM_W);

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_ELEMENT = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_VALUE_MAX = 1'b1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [VALUE_W-1:0]  value;
    logic [RANDOM_W-1:0] random_word;
  } item_t;

  typedef struct packed {
    logic [NEW_VALUE_W-1:0] new_value;
    logic                   is_final;
    logic                   error;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FOLD,
    ST_ADJUST,
    ST_EMIT
  } state_t;

endpackage

>>> design/spr_rem.sv
// Bit-serial restoring remainder: 32-bit word modulo a narrow range size.
`timescale 1ns / 1ps

module spr_rem
  import spr_pkg::*;
#(
  parameter int VALUE_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RANDOM_W-1:0]   dividend,
  input  logic [VALUE_BITS:0]   divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] rem
);

  logic [RANDOM_W-1:0] shreg;
  logic [CNT_W-1:0]    count;
  logic                busy;
  logic [VALUE_BITS:0] trial;

  // Bring down one dividend bit per cycle, most significant first.
  assign trial = {rem, shreg[RANDOM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(RANDOM_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[RANDOM_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem <= VALUE_BITS'(trial - divisor);
      end else begin
        rem <= trial[VALUE_BITS-1:0];
      end
    end
  end

endmodule

>>> design/sum_preserving_pair_resampler_unit.sv
// Top level of the sum-preserving pair resampler.
`timescale 1ns / 1ps
//
// Usage:
//   item channel (item_valid / item_stall / item) carries start, element and
//   finish words. A start word loads the carried element into the budget and
//   gives no result. Element and finish words each give one result word on
//   the result channel (result_valid / result_stall / result).
//   Throughput: one word at a time. An element in range passes through load,
//   the remainder unit (each bit of random_word in turn, most significant
//   first, then a done flag), fold, adjust and emit. The next word can be
//   taken from the cycle in which the result appears. Finish words and
//   rejected elements go from load straight to emit; start and ignored words
//   go from load back to idle and give no result.
//   The output register holds a finished result while the receiver stalls;
//   the next word is taken meanwhile, and its result waits in the emit step
//   until the output register frees up.
//   Reset (rst, synchronous) clears the budget, closes the block, drops any
//   pending result and sets direction to 0 and value_max to all ones.
//   Config writes (cfg_write / cfg_index / cfg_data) are registered and
//   are expected only while the unit is idle.

module sum_preserving_pair_resampler_unit
  import spr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VALUE_BITS = VALUE_W;
  localparam int BW = VALUE_BITS + 1;

  state_t state, state_next;

  logic                  direction;
  logic [VALUE_BITS-1:0] value_max;
  logic [BW-1:0]         running_budget;
  logic                  block_open;

  logic [1:0]            kind_q;
  logic [VALUE_BITS-1:0] x_q;
  logic [RANDOM_W-1:0]   rw_q;

  logic [BW-1:0] budget_q;
  logic [BW-1:0] lo_q;
  logic [BW-1:0] size_q;
  logic [BW-1:0] off_q;
  logic [BW-1:0] shifted_q;

  logic [BW-1:0] pend_value;
  logic [BW-1:0] pend_budget;
  logic          pend_open;
  logic          pend_final;
  logic          pend_error;
  logic          pend_update;

  logic                  rem_start;
  logic                  rem_done;
  logic [VALUE_BITS-1:0] rem;

  logic accept;
  logic emit_load;

  // Range check on the latched item.
  logic [BW-1:0] x_e, vmax_e, budget, lo, hi, size;
  logic          bad;
  logic          range_ok;

  always_comb begin
    x_e    = BW'(x_q);
    vmax_e = BW'(value_max);
    budget = running_budget + x_e;
    lo     = (budget > vmax_e) ? budget - vmax_e : '0;
    hi     = (budget < vmax_e) ? budget : vmax_e;
    bad    = (lo > hi) || (x_e < lo) || (x_e > hi);
    size   = hi - lo + 1'b1;
  end

  assign range_ok = (kind_q == KIND_ELEMENT) && block_open && !bad;

  // Fold and adjust arithmetic.
  logic [BW-1:0] rem_e, shift, pos, y;

  always_comb begin
    rem_e = BW'(rem);
    shift = direction ? size_q - rem_e : rem_e;
    pos   = (shifted_q >= size_q) ? shifted_q - size_q : shifted_q;
    y     = pos + lo_q;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (kind_q == KIND_FINISH || kind_q == KIND_ELEMENT) begin
          state_next = range_ok ? ST_DIVIDE : ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (rem_done) state_next = ST_FOLD;
      end
      ST_FOLD:   state_next = ST_ADJUST;
      ST_ADJUST: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    item_stall = 1'b1;
    rem_start  = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_IDLE:   item_stall = 1'b0;
      ST_LOAD:   rem_start  = range_ok;
      ST_EMIT:   emit_load  = !result_valid || !result_stall;
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      value_max <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_VALUE_MAX: value_max <= VALUE_BITS'(cfg_data);
        default:       direction <= direction;
      endcase
    end
  end

  // Budget and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_budget <= '0;
      block_open     <= 1'b0;
    end else if (state == ST_LOAD && kind_q == KIND_START) begin
      running_budget <= x_e;
      block_open     <= 1'b1;
    end else if (emit_load && pend_update) begin
      running_budget <= pend_budget;
      block_open     <= pend_open;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.new_value <= NEW_VALUE_W'(pend_value);
      result.is_final  <= pend_final;
      result.error     <= pend_error;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= item.kind;
      x_q    <= VALUE_BITS'(item.value);
      rw_q   <= item.random_word;
    end
    unique case (state)
      ST_LOAD: begin
        budget_q    <= budget;
        lo_q        <= lo;
        size_q      <= size;
        off_q       <= x_e - lo;
        pend_final  <= 1'b0;
        pend_error  <= 1'b1;
        pend_value  <= x_e;
        pend_update <= 1'b0;
        pend_budget <= running_budget;
        pend_open   <= block_open;
        if (kind_q == KIND_FINISH) begin
          // Emit the carry and close the block.
          pend_value  <= running_budget;
          pend_final  <= 1'b1;
          pend_error  <= !block_open;
          pend_update <= 1'b1;
          pend_budget <= '0;
          pend_open   <= 1'b0;
        end
      end
      ST_FOLD: begin
        shifted_q <= off_q + shift;
      end
      ST_ADJUST: begin
        pend_value  <= y;
        pend_error  <= 1'b0;
        pend_final  <= 1'b0;
        pend_budget <= budget_q - y;
        pend_open   <= 1'b1;
        pend_update <= 1'b1;
      end
      default: begin
        shifted_q <= shifted_q;
      end
    endcase
  end

  spr_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rw_q),
    .divisor  (size),
    .done     (rem_done),
    .rem      (rem)
  );

endmodule
